// File: design/bpd_pkg.sv
`default_nettype none

package bpd_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 24;

  localparam int CH_BITS     = 4;
  localparam int SPP_BITS    = 24;
  localparam int PC_BITS     = 16;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  typedef logic [SAMPLE_BITS-1:0] mag_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT    = 2'd0,
    REG_SAMPLES_PER_PEAK = 2'd1,
    REG_PEAK_COUNT       = 2'd2,
    REG_UNUSED           = 2'd3
  } reg_idx_t;

  localparam logic [CH_BITS-1:0]  CHANNEL_COUNT_RESET    = CH_BITS'(1);
  localparam logic [SPP_BITS-1:0] SAMPLES_PER_PEAK_RESET = SPP_BITS'(1);
  localparam logic [PC_BITS-1:0]  PEAK_COUNT_RESET       = PC_BITS'(256);

  function automatic mag_t sample_mag(input sample_t s);
    mag_t v;
    v = mag_t'(s);
    if (v[SAMPLE_BITS-1]) begin
      return mag_t'(~v + mag_t'(1));
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: design/block_peak_decimator_top.sv
// Channel   | Ports                                      | Handshake
// in        | in_start_of_clip, in_sample_0..7           | in_valid / in_stall
// out       | out_peak_index, out_peak_magnitude, ...    | out_valid / out_stall
// cfg       | psel, penable, pwrite, paddr, pwdata, ...  | APB write, pready tied high
//
// One item per cycle sustained while the output does not stall.
// The frame peak is formed ahead of the input register, the block state is updated
// in the next stage, which loads the result register.
// Reset is synchronous on rst_n and restores the register defaults and clip state.
// A stall on the output holds the result register; one more item waits in the input
// register before in_stall rises.
`default_nettype none

module block_peak_decimator_top
  import bpd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_start_of_clip,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_0,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_1,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_2,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_3,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_4,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_5,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_6,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_7,

  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [PC_BITS-1:0]          out_peak_index,
  output logic [SAMPLE_BITS-1:0]      out_peak_magnitude,
  output logic                        out_last_peak,

  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ADDR_BITS-1:0]   paddr,
  input  wire logic [DATA_BITS-1:0]   pwdata,
  output logic [DATA_BITS-1:0]        prdata,
  output logic                        pready
);

  logic [CH_BITS-1:0]  channel_count_r;
  logic [SPP_BITS-1:0] samples_per_peak_r;
  logic [PC_BITS-1:0]  peak_count_r;

  reg_idx_t reg_sel;
  logic     cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r    <= CHANNEL_COUNT_RESET;
      samples_per_peak_r <= SAMPLES_PER_PEAK_RESET;
      peak_count_r       <= PEAK_COUNT_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_CHANNEL_COUNT:    channel_count_r    <= pwdata[CH_BITS-1:0];
        REG_SAMPLES_PER_PEAK: samples_per_peak_r <= pwdata[SPP_BITS-1:0];
        REG_PEAK_COUNT:       peak_count_r       <= pwdata[PC_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CHANNEL_COUNT:    prdata = DATA_BITS'(channel_count_r);
      REG_SAMPLES_PER_PEAK: prdata = DATA_BITS'(samples_per_peak_r);
      REG_PEAK_COUNT:       prdata = DATA_BITS'(peak_count_r);
      default:              prdata = '0;
    endcase
  end

  // Frame peak over the active channels, formed ahead of the input register.
  logic [SAMPLE_BITS-1:0] samples [MAX_CHANNELS];
  logic [CH_BITS-1:0]     chans;
  mag_t                   frame_max;

  assign samples[0] = in_sample_0;
  assign samples[1] = in_sample_1;
  assign samples[2] = in_sample_2;
  assign samples[3] = in_sample_3;
  assign samples[4] = in_sample_4;
  assign samples[5] = in_sample_5;
  assign samples[6] = in_sample_6;
  assign samples[7] = in_sample_7;

  always_comb begin
    mag_t m;
    if (channel_count_r == '0) begin
      chans = CH_BITS'(1);
    end else if (channel_count_r > CH_BITS'(MAX_CHANNELS)) begin
      chans = CH_BITS'(MAX_CHANNELS);
    end else begin
      chans = channel_count_r;
    end
    frame_max = '0;
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      m = sample_mag(sample_t'(samples[ch]));
      if (CH_BITS'(ch) < chans && m > frame_max) begin
        frame_max = m;
      end
    end
  end

  logic s1_valid_r;
  logic s1_start_r;
  mag_t s1_max_r;
  logic advance;
  logic in_fire;
  logic s1_fire;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;
  assign s1_fire  = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_start_r <= in_start_of_clip;
      s1_max_r   <= frame_max;
    end
  end

  // Block state update.
  logic [SPP_BITS-1:0] frame_in_block_r, frame_in_block_nxt;
  logic [PC_BITS-1:0]  block_index_r, block_index_nxt;
  mag_t                running_max_r, running_max_nxt;
  logic                clip_done_r, clip_done_nxt;

  logic [SPP_BITS-1:0] spp_eff;
  logic [PC_BITS-1:0]  pc_eff;
  logic [SPP_BITS-1:0] fib_cur, fib_inc;
  logic [PC_BITS-1:0]  bi_cur;
  mag_t                rm_cur, rm_upd;
  logic                done_cur;
  logic                emit;
  logic                last;

  assign spp_eff = (samples_per_peak_r == '0) ? SPP_BITS'(1) : samples_per_peak_r;
  assign pc_eff  = (peak_count_r == '0) ? PC_BITS'(1) : peak_count_r;

  always_comb begin
    fib_cur  = s1_start_r ? '0 : frame_in_block_r;
    bi_cur   = s1_start_r ? '0 : block_index_r;
    rm_cur   = s1_start_r ? '0 : running_max_r;
    done_cur = s1_start_r ? 1'b0 : clip_done_r;

    rm_upd  = (s1_max_r > rm_cur) ? s1_max_r : rm_cur;
    fib_inc = fib_cur + SPP_BITS'(1);
    emit    = !done_cur && (fib_inc >= spp_eff);
    last    = ({1'b0, bi_cur} + (PC_BITS+1)'(1)) >= {1'b0, pc_eff};

    frame_in_block_nxt = fib_cur;
    block_index_nxt    = bi_cur;
    running_max_nxt    = rm_cur;
    clip_done_nxt      = done_cur;
    if (!done_cur) begin
      if (emit) begin
        frame_in_block_nxt = '0;
        running_max_nxt    = '0;
        if (last) begin
          clip_done_nxt = 1'b1;
        end else begin
          block_index_nxt = bi_cur + PC_BITS'(1);
        end
      end else begin
        frame_in_block_nxt = fib_inc;
        running_max_nxt    = rm_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_in_block_r <= '0;
      block_index_r    <= '0;
      running_max_r    <= '0;
      clip_done_r      <= 1'b0;
    end else if (s1_fire) begin
      frame_in_block_r <= frame_in_block_nxt;
      block_index_r    <= block_index_nxt;
      running_max_r    <= running_max_nxt;
      clip_done_r      <= clip_done_nxt;
    end
  end

  // Result register.
  logic out_valid_r;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_peak_index     <= bi_cur;
      out_peak_magnitude <= rm_upd;
      out_last_peak      <= last;
    end
  end

endmodule

`default_nettype wire

// File: verif/bpd_checker.sv
`timescale 1ns / 100ps

module bpd_checker
  import bpd_pkg::*;
(
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  input  wire logic                                    in_stall,
  input  wire logic                                    in_start_of_clip,
  input  wire logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] in_frame,
  input  wire logic                                    out_valid,
  input  wire logic                                    out_stall,
  input  wire logic [PC_BITS-1:0]                      out_peak_index,
  input  wire logic [SAMPLE_BITS-1:0]                  out_peak_magnitude,
  input  wire logic                                    out_last_peak,
  input  wire logic                                    psel,
  input  wire logic                                    penable,
  input  wire logic                                    pwrite,
  input  wire logic                                    pready,
  input  wire logic [ADDR_BITS-1:0]                    paddr,
  input  wire logic [DATA_BITS-1:0]                    pwdata,
  output int                                           pending,
  output int                                           errors,
  output int                                           frames_used
);

  typedef struct packed {
    logic [PC_BITS-1:0] index;
    mag_t               magnitude;
    logic               last;
  } peak_t;

  logic [CH_BITS-1:0]  chan_cfg;
  logic [SPP_BITS-1:0] spp_cfg;
  logic [PC_BITS-1:0]  pc_cfg;

  logic [SPP_BITS-1:0] frame_in_block;
  logic [PC_BITS-1:0]  block_index;
  mag_t                running_max;
  logic                clip_done;

  peak_t peak_q[$];
  peak_t new_peak;
  peak_t want;
  logic  has_peak;
  logic  took;
  int    err_cnt;
  int    used_cnt;

  function automatic mag_t abs_sample(input logic [SAMPLE_BITS-1:0] raw);
    return raw[SAMPLE_BITS-1] ? mag_t'(-raw) : raw;
  endfunction

  function automatic logic fold_frame(input logic sof,
                                      input logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] frame,
                                      output peak_t pk, output logic used);
    int                  chans;
    logic [SPP_BITS-1:0] spp;
    logic [PC_BITS-1:0]  pc;
    mag_t                frame_max;
    if (chan_cfg == '0) begin
      chans = 1;
    end else if (chan_cfg > CH_BITS'(MAX_CHANNELS)) begin
      chans = MAX_CHANNELS;
    end else begin
      chans = int'(chan_cfg);
    end
    spp = (spp_cfg == '0) ? SPP_BITS'(1) : spp_cfg;
    pc = (pc_cfg == '0) ? PC_BITS'(1) : pc_cfg;
    pk = '0;
    used = 1'b0;
    if (sof) begin
      frame_in_block = '0;
      block_index = '0;
      running_max = '0;
      clip_done = 1'b0;
    end
    if (clip_done) return 1'b0;
    used = 1'b1;
    frame_max = '0;
    for (int c = 0; c < chans; c++) begin
      if (abs_sample(frame[c]) > frame_max) frame_max = abs_sample(frame[c]);
    end
    if (frame_max > running_max) running_max = frame_max;
    frame_in_block = frame_in_block + 1'b1;
    if (frame_in_block < spp) return 1'b0;
    pk.index = block_index;
    pk.magnitude = running_max;
    pk.last = ({1'b0, block_index} + 17'd1) >= {1'b0, pc};
    running_max = '0;
    frame_in_block = '0;
    if (pk.last) begin
      clip_done = 1'b1;
    end else begin
      block_index = block_index + 1'b1;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      chan_cfg = CHANNEL_COUNT_RESET;
      spp_cfg = SAMPLES_PER_PEAK_RESET;
      pc_cfg = PEAK_COUNT_RESET;
      frame_in_block = '0;
      block_index = '0;
      running_max = '0;
      clip_done = 1'b0;
      peak_q.delete();
      err_cnt = 0;
      used_cnt = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_BITS-1:2]))
          REG_CHANNEL_COUNT:    chan_cfg = pwdata[CH_BITS-1:0];
          REG_SAMPLES_PER_PEAK: spp_cfg = pwdata[SPP_BITS-1:0];
          REG_PEAK_COUNT:       pc_cfg = pwdata[PC_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (peak_q.size() == 0) begin
          $error("unexpected peak: index %0d magnitude %0d last %0b",
                 out_peak_index, out_peak_magnitude, out_last_peak);
          err_cnt++;
        end else begin
          want = peak_q.pop_front();
          if (out_peak_index !== want.index) begin
            $error("peak_index mismatch: expected %0d, actual %0d", want.index, out_peak_index);
            err_cnt++;
          end
          if (out_peak_magnitude !== want.magnitude) begin
            $error("peak_magnitude mismatch: expected %0d, actual %0d",
                   want.magnitude, out_peak_magnitude);
            err_cnt++;
          end
          if (out_last_peak !== want.last) begin
            $error("last_peak mismatch: expected %0b, actual %0b", want.last, out_last_peak);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        has_peak = fold_frame(in_start_of_clip, in_frame, new_peak, took);
        if (took) used_cnt++;
        if (has_peak) peak_q.insert(peak_q.size(), new_peak);
      end
    end
    pending <= peak_q.size();
    errors <= err_cnt;
    frames_used <= used_cnt;
  end

endmodule

// File: verif/tb_block_peak_decimator_top.sv
`timescale 1ns / 100ps

module tb_block_peak_decimator_top;
  import bpd_pkg::*;

  typedef logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] frame_t;

  localparam int TARGET_FRAMES = 1900;
  localparam int QUIET_FROM    = 1700;
  localparam int LONG_HOLD     = 200;
  localparam int DRAIN_CYCLES  = 6;

  localparam logic [SAMPLE_BITS-1:0] FULL_POS  = 24'h7FFFFF;
  localparam logic [SAMPLE_BITS-1:0] FULL_NEG  = 24'h800000;
  localparam logic [SAMPLE_BITS-1:0] MINUS_ONE = 24'hFFFFFF;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_start_of_clip;
  frame_t                 in_frame;
  logic                   out_valid;
  logic                   out_stall;
  logic [PC_BITS-1:0]     out_peak_index;
  logic [SAMPLE_BITS-1:0] out_peak_magnitude;
  logic                   out_last_peak;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_BITS-1:0]   paddr;
  logic [DATA_BITS-1:0]   pwdata;
  logic [DATA_BITS-1:0]   prdata;
  logic                   pready;

  logic quiet;
  logic hold_req;
  int   pending;
  int   errors;
  int   frames_used;

  block_peak_decimator_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_start_of_clip   (in_start_of_clip),
    .in_sample_0        (in_frame[0]),
    .in_sample_1        (in_frame[1]),
    .in_sample_2        (in_frame[2]),
    .in_sample_3        (in_frame[3]),
    .in_sample_4        (in_frame[4]),
    .in_sample_5        (in_frame[5]),
    .in_sample_6        (in_frame[6]),
    .in_sample_7        (in_frame[7]),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_peak_index     (out_peak_index),
    .out_peak_magnitude (out_peak_magnitude),
    .out_last_peak      (out_last_peak),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  bpd_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_start_of_clip   (in_start_of_clip),
    .in_frame           (in_frame),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_peak_index     (out_peak_index),
    .out_peak_magnitude (out_peak_magnitude),
    .out_last_peak      (out_last_peak),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pending            (pending),
    .errors             (errors),
    .frames_used        (frames_used)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return FULL_POS;
      1: return FULL_NEG;
      2: return '0;
      3: return MINUS_ONE;
      4: return SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    for (int c = 0; c < MAX_CHANNELS; c++) f[c] = pick_sample();
    return f;
  endfunction

  function automatic frame_t fill_frame(input logic [SAMPLE_BITS-1:0] v);
    frame_t f;
    for (int c = 0; c < MAX_CHANNELS; c++) f[c] = v;
    return f;
  endfunction

  task automatic send_frame(input logic sof, input frame_t f);
    int gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_start_of_clip <= sof;
    in_frame <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [DATA_BITS-1:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_BITS'({r, 2'b00});
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input logic [CH_BITS-1:0] ch, input logic [SPP_BITS-1:0] spp,
                           input logic [PC_BITS-1:0] pc);
    wait_idle();
    write_reg(REG_CHANNEL_COUNT, DATA_BITS'(ch));
    write_reg(REG_SAMPLES_PER_PEAK, DATA_BITS'(spp));
    write_reg(REG_PEAK_COUNT, DATA_BITS'(pc));
  endtask

  task automatic random_phase(input logic stress);
    logic [CH_BITS-1:0]  ch;
    logic [SPP_BITS-1:0] spp;
    logic [PC_BITS-1:0]  pc;
    int                  spp_eff;
    int                  pc_eff;
    int                  n;
    ch = CH_BITS'($urandom_range(0, 15));
    case ($urandom_range(0, 19))
      0:       spp = '0;
      1:       spp = '1;
      2, 3:    spp = SPP_BITS'($urandom_range(9, 40));
      default: spp = SPP_BITS'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 19))
      0:       pc = '0;
      1:       pc = '1;
      2, 3:    pc = PC_BITS'($urandom_range(13, 40));
      default: pc = PC_BITS'($urandom_range(1, 12));
    endcase
    if (stress) begin
      ch = CH_BITS'(MAX_CHANNELS);
      spp = SPP_BITS'(1);
      pc = PC_BITS'(200);
    end
    configure(ch, spp, pc);
    spp_eff = (spp == '0) ? 1 : int'(spp);
    pc_eff = (pc == '0) ? 1 : int'(pc);
    if (spp_eff > 1000) begin
      n = $urandom_range(2, 6);
    end else begin
      n = spp_eff * pc_eff + $urandom_range(0, 4);
      if (n > 150) n = 150;
    end
    if (stress) begin
      n = 80;
      hold_req = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      send_frame((k == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 39) == 0,
                 random_frame());
    end
    release_input();
  endtask

  initial begin
    frame_t f;
    int     guard;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_start_of_clip = 1'b0;
    in_frame = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings, and a clip that starts without a start flag.
    send_frame(1'b0, fill_frame(FULL_POS));
    send_frame(1'b0, fill_frame(FULL_NEG));
    send_frame(1'b0, fill_frame('0));
    send_frame(1'b0, fill_frame(MINUS_ONE));
    f = fill_frame(FULL_NEG);
    f[0] = '0;
    send_frame(1'b0, f);
    release_input();

    // A short clip, then frames past its last peak, then a fresh start.
    configure(CH_BITS'(MAX_CHANNELS), SPP_BITS'(2), PC_BITS'(3));
    f = fill_frame('0);
    f[MAX_CHANNELS-1] = FULL_NEG;
    send_frame(1'b1, f);
    repeat (7) send_frame(1'b0, random_frame());
    send_frame(1'b1, random_frame());
    release_input();

    configure('1, '0, '0);
    f = fill_frame('0);
    f[MAX_CHANNELS-1] = FULL_POS;
    send_frame(1'b1, f);
    send_frame(1'b0, random_frame());
    release_input();

    // Block length and peak count lowered in the middle of a clip.
    configure('0, SPP_BITS'(4), PC_BITS'(10));
    send_frame(1'b1, random_frame());
    send_frame(1'b0, random_frame());
    release_input();
    configure('0, SPP_BITS'(1), PC_BITS'(10));
    repeat (3) send_frame(1'b0, random_frame());
    release_input();
    configure('0, SPP_BITS'(1), PC_BITS'(2));
    repeat (2) send_frame(1'b0, random_frame());
    release_input();

    configure(CH_BITS'(MAX_CHANNELS), '1, '1);
    send_frame(1'b1, random_frame());
    send_frame(1'b0, random_frame());
    release_input();

    random_phase(1'b1);
    while (frames_used < TARGET_FRAMES) begin
      if (frames_used >= QUIET_FROM) quiet = 1'b1;
      random_phase(1'b0);
    end

    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/bpd_pkg.sv
design/block_peak_decimator_top.sv
verif/bpd_checker.sv
verif/tb_block_peak_decimator_top.sv
